// ===== rtl/jen_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON exponent normalizer package
// Character codes, scanner modes and the record passed from front to back.
// ----------------------------------------------------------------------------
package jen_pkg;

    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_UPPER_E   = 8'h45;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_ONE       = 8'h31;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_IN_STRING  = 3'd1,
        MODE_ESCAPE     = 3'd2,
        MODE_AFTER_E    = 3'd3,
        MODE_AFTER_SIGN = 3'd4,
        MODE_ZEROS      = 3'd5
    } t_mode;

    // Results of one input character: one or two output beats.
    typedef struct packed {
        logic [7:0] first_byte;
        logic       first_has;
        logic       two;
        logic [7:0] second_byte;
        logic       eot;
    } t_entry;

endpackage

// ===== rtl/jen_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input character channel
// Valid/ready channel carrying one text character and its last flag.
// ----------------------------------------------------------------------------
interface jen_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// ===== rtl/jen_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output character channel
// Valid/ready channel carrying one emitted character and its flags.
// ----------------------------------------------------------------------------
interface jen_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;

    modport source (output valid, output out_byte, output has_byte,
                    output end_of_text, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input end_of_text, output ready);
endinterface

// ===== rtl/jen_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON exponent normalizer front end
// Tracks the scan mode and turns each character into zero, one or two beats.
// ----------------------------------------------------------------------------
module jen_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jen_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output jen_pkg::t_entry o_entry
);
    import jen_pkg::*;

    t_mode      r_mode;
    t_mode      n_mode;
    t_mode      step_mode;
    logic       accept;
    logic [7:0] c;
    logic       slot0;

    assign c         = i_in.in_byte;
    assign i_in.ready = !i_full;
    assign accept    = i_in.valid && !i_full;

    function automatic t_mode plain_mode(input logic [7:0] ch);
        if (ch == CH_QUOTE) begin
            return MODE_IN_STRING;
        end else if (ch == CH_LOWER_E || ch == CH_UPPER_E) begin
            return MODE_AFTER_E;
        end else begin
            return MODE_NORMAL;
        end
    endfunction

    // Next state.
    always_comb begin
        case (r_mode)
            MODE_IN_STRING: begin
                if (c == CH_BACKSLASH) begin
                    step_mode = MODE_ESCAPE;
                end else if (c == CH_QUOTE) begin
                    step_mode = MODE_NORMAL;
                end else begin
                    step_mode = MODE_IN_STRING;
                end
            end
            MODE_ESCAPE: step_mode = MODE_IN_STRING;
            MODE_AFTER_E: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    step_mode = MODE_AFTER_SIGN;
                end else if (c == CH_ZERO) begin
                    step_mode = MODE_ZEROS;
                end else begin
                    step_mode = plain_mode(c);
                end
            end
            MODE_AFTER_SIGN: begin
                step_mode = (c == CH_ZERO) ? MODE_ZEROS : plain_mode(c);
            end
            MODE_ZEROS: begin
                if (c == CH_ZERO) begin
                    step_mode = MODE_ZEROS;
                end else if (c inside {[CH_ONE:CH_NINE]}) begin
                    step_mode = MODE_NORMAL;
                end else begin
                    step_mode = plain_mode(c);
                end
            end
            default: step_mode = plain_mode(c);
        endcase
        n_mode = i_in.is_last ? MODE_NORMAL : step_mode;
    end

    // Outputs.
    always_comb begin
        slot0               = 1'b1;
        o_entry.first_byte  = c;
        o_entry.first_has   = 1'b1;
        o_entry.two         = 1'b0;
        o_entry.second_byte = c;
        o_entry.eot         = i_in.is_last;
        case (r_mode)
            MODE_AFTER_E: begin
                if (c == CH_PLUS || c == CH_ZERO) begin
                    slot0 = 1'b0;
                end
            end
            MODE_AFTER_SIGN: begin
                if (c == CH_ZERO) begin
                    slot0 = 1'b0;
                end
            end
            MODE_ZEROS: begin
                if (c == CH_ZERO) begin
                    slot0 = 1'b0;
                end else if (!(c inside {[CH_ONE:CH_NINE]})) begin
                    // Dropped zeros ended by a non-digit: restore one zero first.
                    o_entry.first_byte = CH_ZERO;
                    o_entry.two        = 1'b1;
                end
            end
            default: slot0 = 1'b1;
        endcase
        if (i_in.is_last && !slot0) begin
            slot0 = 1'b1;
            if (step_mode == MODE_ZEROS) begin
                o_entry.first_byte = CH_ZERO;
            end else begin
                o_entry.first_byte = '0;
                o_entry.first_has  = 1'b0;
            end
        end
        o_push = accept && slot0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

endmodule

// ===== rtl/jen_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON exponent normalizer queue
// Small first-in first-out buffer of result records between front and back.
// ----------------------------------------------------------------------------
module jen_queue #(
    parameter int DEPTH = jen_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jen_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output jen_pkg::t_entry o_entry
);
    import jen_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full   = (r_cnt == FULL_CNT);
    assign o_empty  = (r_cnt == '0);
    assign o_entry  = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/jen_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON exponent normalizer back end
// Holds one result record and sends its one or two beats on the output.
// ----------------------------------------------------------------------------
module jen_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  jen_pkg::t_entry i_entry,
    output logic            o_pop,
    jen_out_if.source       o_out
);
    import jen_pkg::*;

    t_entry r_entry;
    logic   r_valid;
    logic   r_second;
    logic   fire;
    logic   done;

    assign fire = r_valid && o_out.ready;
    // The record is finished once its last beat goes out.
    assign done = r_second || !r_entry.two;
    assign o_pop = !i_empty && (!r_valid || (fire && done));

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_second ? r_entry.second_byte : r_entry.first_byte;
    assign o_out.has_byte    = r_second ? 1'b1 : r_entry.first_has;
    assign o_out.end_of_text = r_entry.eot && done;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (fire) begin
            if (done) begin
                r_valid  <= 1'b0;
                r_second <= 1'b0;
            end else begin
                r_second <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/json_exponent_normalizer_unit.sv =====
`timescale 1ns / 1ps
// Timing: a character accepted at a clock edge is written into the queue at
// that edge; once free, the back end loads it and presents its first beat.
// Throughput: one input character per cycle while the queue is not full; the
// output moves one beat per cycle unless the receiver stalls, so a character
// that yields two beats holds the back end for both of them.
// Reset: synchronous, active low; it returns the scanner to the mode outside any
// string and empties the queue and the output register.
// ----------------------------------------------------------------------------
// JSON exponent normalizer top level
// Rewrites number exponents in a compact JSON character stream.
// ----------------------------------------------------------------------------
//
// Structure:
//   The front end accepts one character per cycle unless the queue is full,
//   tracks whether the scanner is inside a string, after an escape, or inside
//   an exponent, and decides the characters that this input produces. A plus
//   sign after the exponent letter and leading exponent zeros are dropped; when
//   the zeros end without a nonzero digit a single zero is put back. Each
//   character yields one record with up to two bytes and the end-of-text flag.
//
//   Records that carry at least one beat are written into a short queue, so the
//   front end keeps accepting while the output side is stalled. Input ready is
//   simply "queue not full".
//
//   The back end holds the record at the head of the output and presents its
//   beats one per cycle unless stalled. The end-of-text flag is raised only on
//   the last beat of the final character's record; when nothing else is sent
//   for that character, the record is a bare marker beat without a byte.
// ----------------------------------------------------------------------------
module json_exponent_normalizer_unit #(
    parameter int QUEUE_DEPTH = jen_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jen_in_if.sink     i_in,
    jen_out_if.source  o_out
);
    import jen_pkg::*;

    t_entry front_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    jen_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    jen_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (head_entry)
    );

    jen_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== test/tb_json_exponent_normalizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON exponent normalizer testbench
// Feeds short directed texts and then random JSON-like texts through the
// character channel. A behavioral copy of the exponent rewriting rules
// predicts every output beat, and a monitor checks each beat in order.
// Both channels idle at random. The receiver holds off once for a long
// stretch, and the sender waits for the output to drain now and then.
// ----------------------------------------------------------------------------
module tb_json_exponent_normalizer_unit;
    import jen_pkg::*;

    // Bounds of the run.
    localparam int CHAR_TARGET    = 2000;
    localparam int IDLE_PERCENT   = 14;
    localparam int HOLD_AT_CYCLE  = 800;
    localparam int HOLD_CYCLES    = 64;
    localparam int CALM_FIRST     = 1500;
    localparam int CALM_LAST      = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int REPORT_LIMIT   = 10;
    localparam string PUNCT       = "{}[],: ";

    // One character waiting to be sent. When drain_first is set, the sender
    // holds this character back until every predicted beat has arrived.
    typedef struct {
        logic [7:0] ch;
        logic       is_final;
        bit         drain_first;
    } t_char_item;

    // One predicted output beat.
    typedef struct {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_text;
    } t_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    jen_in_if  in_ch ();
    jen_out_if out_ch ();

    json_exponent_normalizer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_char_item char_queue[$];
    t_beat      expected_beats[$];
    t_mode      tracked_mode = MODE_NORMAL;

    int  cycle_no       = 0;
    int  texts_built    = 0;
    int  chars_sent     = 0;
    int  beats_checked  = 0;
    int  bare_markers   = 0;
    int  zeros_restored = 0;
    int  drain_pauses   = 0;
    int  error_count    = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;

    // During the calm window neither side idles at random, so the block runs at
    // full rate for a while.
    wire calm = (cycle_no >= CALM_FIRST) && (cycle_no < CALM_LAST);

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    // ------------------------------------------------------------------------
    // Exponent rewriting predictor
    // ------------------------------------------------------------------------

    // Mode that follows a byte handled as ordinary text outside a string.
    function automatic t_mode mode_after_plain(input logic [7:0] c);
        if (c == CH_QUOTE) begin
            return MODE_IN_STRING;
        end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
            return MODE_AFTER_E;
        end
        return MODE_NORMAL;
    endfunction

    // Works out the beats one accepted character causes and queues them.
    task automatic normalize_char(input logic [7:0] c, input logic is_final);
        t_beat beats[$];
        t_beat marker;
        case (tracked_mode)
            MODE_IN_STRING: begin
                beats.push_back('{c, 1'b1, 1'b0});
                if (c == CH_BACKSLASH) begin
                    tracked_mode = MODE_ESCAPE;
                end else if (c == CH_QUOTE) begin
                    tracked_mode = MODE_NORMAL;
                end
            end
            MODE_ESCAPE: begin
                // The escaped byte never closes the string.
                beats.push_back('{c, 1'b1, 1'b0});
                tracked_mode = MODE_IN_STRING;
            end
            MODE_AFTER_E: begin
                if (c == CH_PLUS) begin
                    tracked_mode = MODE_AFTER_SIGN;
                end else if (c == CH_MINUS) begin
                    beats.push_back('{c, 1'b1, 1'b0});
                    tracked_mode = MODE_AFTER_SIGN;
                end else if (c == CH_ZERO) begin
                    tracked_mode = MODE_ZEROS;
                end else begin
                    beats.push_back('{c, 1'b1, 1'b0});
                    tracked_mode = mode_after_plain(c);
                end
            end
            MODE_AFTER_SIGN: begin
                // A second sign is just an ordinary byte.
                if (c == CH_ZERO) begin
                    tracked_mode = MODE_ZEROS;
                end else begin
                    beats.push_back('{c, 1'b1, 1'b0});
                    tracked_mode = mode_after_plain(c);
                end
            end
            MODE_ZEROS: begin
                if (c == CH_ZERO) begin
                    // Still inside the run of leading zeros.
                end else if (c > CH_ZERO && c <= CH_NINE) begin
                    beats.push_back('{c, 1'b1, 1'b0});
                    tracked_mode = MODE_NORMAL;
                end else begin
                    // The zeros ended without a nonzero digit: one comes back,
                    // then the byte is handled as ordinary text.
                    beats.push_back('{CH_ZERO, 1'b1, 1'b0});
                    beats.push_back('{c, 1'b1, 1'b0});
                    tracked_mode = mode_after_plain(c);
                    zeros_restored++;
                end
            end
            default: begin
                beats.push_back('{c, 1'b1, 1'b0});
                tracked_mode = mode_after_plain(c);
            end
        endcase

        if (is_final) begin
            if (tracked_mode == MODE_ZEROS) begin
                beats.push_back('{CH_ZERO, 1'b1, 1'b0});
                zeros_restored++;
            end
            if (beats.size() == 0) begin
                beats.push_back('{8'h00, 1'b0, 1'b0});
                bare_markers++;
            end
            marker = beats.pop_back();
            marker.end_of_text = 1'b1;
            beats.push_back(marker);
            tracked_mode = MODE_NORMAL;
        end

        foreach (beats[i]) begin
            expected_beats.push_back(beats[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    // Queues one text; its final character carries the last flag.
    task automatic add_text(input logic [7:0] txt[$], input bit drain);
        t_char_item item;
        foreach (txt[i]) begin
            item.ch          = txt[i];
            item.is_final    = (i == txt.size() - 1);
            item.drain_first = drain && (i == 0);
            char_queue.push_back(item);
        end
        texts_built++;
    endtask

    task automatic add_string(input string s);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) begin
            txt.push_back(s[i]);
        end
        add_text(txt, 1'b0);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_sign();
        return $urandom_range(1) ? CH_PLUS : CH_MINUS;
    endfunction

    // Builds one JSON-like text: mostly numbers with exponents and strings
    // with escapes, with some punctuation, stray bytes and unclosed strings.
    // A text may stop in the middle of an exponent.
    task automatic add_random_text(input bit drain);
        logic [7:0] txt[$];
        int         kind;
        repeat ($urandom_range(12, 1)) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                if ($urandom_range(3) == 0) begin
                    txt.push_back(CH_MINUS);
                end
                repeat ($urandom_range(3, 1)) txt.push_back(rand_digit());
                if ($urandom_range(2) == 0) begin
                    txt.push_back(8'h2E);
                    repeat ($urandom_range(3, 1)) txt.push_back(rand_digit());
                end
                if ($urandom_range(9) < 8) begin
                    txt.push_back($urandom_range(1) ? CH_LOWER_E : CH_UPPER_E);
                    case ($urandom_range(9))
                        0, 1, 2: txt.push_back(CH_PLUS);
                        3, 4, 5: txt.push_back(CH_MINUS);
                        6: begin
                            txt.push_back(rand_sign());
                            txt.push_back(rand_sign());
                        end
                        default: ;
                    endcase
                    repeat ($urandom_range(4)) txt.push_back(CH_ZERO);
                    repeat ($urandom_range(3)) txt.push_back(rand_digit());
                end
            end else if (kind < 65) begin
                txt.push_back(CH_QUOTE);
                repeat ($urandom_range(6)) begin
                    if ($urandom_range(4) == 0) begin
                        txt.push_back(CH_BACKSLASH);
                        case ($urandom_range(3))
                            0:       txt.push_back(CH_QUOTE);
                            1:       txt.push_back(CH_BACKSLASH);
                            2:       txt.push_back(CH_LOWER_E);
                            default: txt.push_back(8'($urandom_range(255)));
                        endcase
                    end else if ($urandom_range(5) == 0) begin
                        txt.push_back($urandom_range(1) ? CH_UPPER_E : CH_ZERO);
                    end else begin
                        txt.push_back(8'($urandom_range(126, 32)));
                    end
                end
                if ($urandom_range(9) != 0) begin
                    txt.push_back(CH_QUOTE);
                end
            end else if (kind < 90) begin
                txt.push_back(PUNCT[$urandom_range(PUNCT.len() - 1)]);
            end else begin
                txt.push_back(8'($urandom_range(255)));
            end
        end
        add_text(txt, drain);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offers queued characters and predicts each accepted beat.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.in_byte <= 8'h00;
            in_ch.is_last <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                normalize_char(in_ch.in_byte, in_ch.is_last);
                chars_sent++;
            end
            // A new character may be offered once the current one is taken.
            if (!in_ch.valid || in_ch.ready) begin
                if (char_queue.size() != 0
                        && !(char_queue[0].drain_first && expected_beats.size() != 0)
                        && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                    if (char_queue[0].drain_first) begin
                        drain_pauses++;
                    end
                    in_ch.valid   <= 1'b1;
                    in_ch.in_byte <= char_queue[0].ch;
                    in_ch.is_last <= char_queue[0].is_final;
                    void'(char_queue.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver: random stalls plus one long hold-off, during which the
    // internal queue fills up and the input side has to stall.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && cycle_no >= HOLD_AT_CYCLE) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: each accepted beat against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("beat %0d not predicted: byte %02h has %0b eot %0b",
                             beats_checked, out_ch.out_byte, out_ch.has_byte,
                             out_ch.end_of_text);
                end
            end else begin
                want = expected_beats.pop_front();
                if (out_ch.out_byte !== want.out_byte
                        || out_ch.has_byte !== want.has_byte
                        || out_ch.end_of_text !== want.end_of_text) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("beat %0d: expected byte %02h has %0b eot %0b, got byte %02h has %0b eot %0b",
                                 beats_checked, want.out_byte, want.has_byte,
                                 want.end_of_text, out_ch.out_byte, out_ch.has_byte,
                                 out_ch.end_of_text);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when neither channel moves a beat for too long.
    // ------------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] raw[$];

        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.is_last = 1'b0;
        out_ch.ready  = 1'b0;

        // Directed texts. A dropped plus with zeros still pending at the
        // last character.
        add_string("e+00");
        // Kept minus, zeros before a nonzero digit, zeros ended by a quote,
        // and an escaped quote that leaves the string open.
        add_string("E-05e0\"a\\\"");
        // Zeros ended by a new exponent letter, then a doubled sign.
        add_string("e0e--");
        // An exponent with no digits whose last character emits no byte.
        add_string("e+");
        // Both extreme byte values.
        raw.push_back(8'h00);
        raw.push_back(8'hFF);
        add_text(raw, 1'b0);

        // Random texts; every sixteenth one waits for the output to drain.
        while (char_queue.size() < CHAR_TARGET) begin
            add_random_text(texts_built % 16 == 15);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_queue.size() != 0 || in_ch.valid || expected_beats.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("%0d texts, %0d characters sent, %0d beats checked", texts_built,
                 chars_sent, beats_checked);
        $display("%0d bare end markers, %0d restored zeros, %0d drain pauses",
                 bare_markers, zeros_restored, drain_pauses);
        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d beats never arrived", error_count,
                     expected_beats.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
